// ----- hw/rtl/rsk_pkg.sv -----
// ----------------------------------------------------------------------------
// Record sort package
// Shared types and defaults for the keyed record exchange sorter.
// ----------------------------------------------------------------------------
package rsk_pkg;

  localparam int MAX_RECORDS_DEF = 64;

  typedef struct packed {
    logic [31:0] sort_key;
    logic [15:0] record_tag;
    logic        last_record;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sorted_key;
    logic [15:0] sorted_tag;
    logic        end_of_run;
    logic        records_dropped;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] tag;
  } record_t;

endpackage

// ----- hw/rtl/rsk_mem.sv -----
// ----------------------------------------------------------------------------
// Record store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module rsk_mem
  import rsk_pkg::*;
#(
  parameter int DEPTH = MAX_RECORDS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  record_t                  wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output record_t                  rd_data
);

  record_t mem_r [DEPTH];
  record_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/record_exchange_sort_by_key_top.sv -----
// Records load at one per cycle while loading (in_stall is high otherwise); the batch is held in one record store.
// Sorting does one compare per store read.
// Each result then takes a store read and the output register load, and is held while out_stall is high.
// Synchronous reset empties the batch and selects ascending order.
// ----------------------------------------------------------------------------
// Record exchange sorter
// Collects keyed records, sorts them by key with an exchange sort held in a
// memory, then returns them in order with the final one marked.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_key_top
  import rsk_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int ADDR_W = $clog2(MAX_RECORDS);
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_RDI   = 3'd1;
  localparam logic [2:0] S_GETI  = 3'd2;
  localparam logic [2:0] S_INNER = 3'd3;
  localparam logic [2:0] S_WRI   = 3'd4;
  localparam logic [2:0] S_ERD   = 3'd5;
  localparam logic [2:0] S_EGET  = 3'd6;
  localparam logic [2:0] S_EOUT  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              asc_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [ADDR_W-1:0] wj_r, wj_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  record_t           cur_r, cur_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  record_t           mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  record_t           mem_rdata;

  logic              in_fire;
  logic [CNT_W-1:0]  n_new;
  logic              swap;
  logic              last_k;

  rsk_mem #(
    .DEPTH(MAX_RECORDS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign in_stall  = (state_r != S_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign swap   = asc_r ? (cur_r.key > mem_rdata.key) : (cur_r.key < mem_rdata.key);
  assign last_k = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    wj_nxt        = wj_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = cur_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    n_new         = count_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (count_r < CNT_W'(MAX_RECORDS)) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[ADDR_W-1:0];
            mem_wdata = record_t'{key: in_item.sort_key, tag: in_item.record_tag};
            n_new     = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          count_nxt = n_new;
          if (in_item.last_record) begin
            i_nxt = '0;
            k_nxt = '0;
            if (n_new >= CNT_W'(2)) begin
              state_nxt = S_RDI;
            end else begin
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_RDI: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
        state_nxt = S_GETI;
      end
      S_GETI: begin
        cur_nxt   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = i_r + ADDR_W'(1);
        wj_nxt    = i_r + ADDR_W'(1);
        j_nxt     = CNT_W'(i_r) + CNT_W'(2);
        state_nxt = S_INNER;
      end
      S_INNER: begin
        if (swap) begin
          mem_we    = 1'b1;
          mem_waddr = wj_r;
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata;
        end
        if (j_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = j_r[ADDR_W-1:0];
          wj_nxt    = j_r[ADDR_W-1:0];
          j_nxt     = j_r + CNT_W'(1);
        end else begin
          state_nxt = S_WRI;
        end
      end
      S_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = cur_r;
        if ((CNT_W'(i_r) + CNT_W'(2)) < count_r) begin
          i_nxt     = i_r + ADDR_W'(1);
          state_nxt = S_RDI;
        end else begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        mem_re    = 1'b1;
        mem_raddr = k_r;
        state_nxt = S_EGET;
      end
      S_EGET: begin
        out_item_nxt.sorted_key      = mem_rdata.key;
        out_item_nxt.sorted_tag      = mem_rdata.tag;
        out_item_nxt.end_of_run      = last_k;
        out_item_nxt.records_dropped = ovf_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EOUT;
      end
      S_EOUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (last_k) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + ADDR_W'(1);
            mem_re    = 1'b1;
            mem_raddr = k_r + ADDR_W'(1);
            state_nxt = S_EGET;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      asc_r       <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        asc_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    wj_r       <= wj_nxt;
    k_r        <= k_nxt;
    cur_r      <= cur_nxt;
  end

endmodule
